>>> rtl/slbc_pkg.sv
// Shared types, constants and helpers for the serial line buffer controller.
package slbc_pkg;

   // Ring geometry and counter widths
   localparam int RING_DEPTH = 64;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int FILL_W     = RING_AW + 1;
   localparam int CNT_W      = 6;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 4;

   localparam logic [CNT_W-1:0]  MAX_REQUEST = CNT_W'(63);
   localparam logic [BYTE_W-1:0] CR_BYTE     = 8'h0D;

   typedef enum logic [1:0] {
      OP_RX_BYTE  = 2'd0,
      OP_READ     = 2'd1,
      OP_WRITE    = 2'd2,
      OP_TX_READY = 2'd3
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      K_BYTE    = 4'd0,
      K_RDONE   = 4'd1,
      K_RPEND   = 4'd2,
      K_BUF     = 4'd3,
      K_DROP    = 4'd4,
      K_TX      = 4'd5,
      K_WDONE   = 4'd6,
      K_BUSY    = 4'd7,
      K_CLOSED  = 4'd8,
      K_IGNORED = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_DRAIN = 2'd1,
      S_FETCH = 2'd2,
      S_RDONE = 2'd3
   } state_type;

   // Saturate a request count to the largest transfer
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
      clamp_count = (c > MAX_REQUEST) ? MAX_REQUEST : c;
   endfunction

endpackage

>>> rtl/slbc_req_if.sv
// Request channel interface: opcode, data byte and count with valid/ready.
interface slbc_req_if import slbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic [BYTE_W-1:0]   data_byte;
   logic [CNT_W-1:0]    request_count;

   modport source (output valid, opcode, data_byte, request_count, input ready);
   modport sink   (input valid, opcode, data_byte, request_count, output ready);
endinterface

>>> rtl/slbc_rsp_if.sv
// Response channel interface: result kind, byte, count and last flag with valid/ready.
interface slbc_rsp_if import slbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BYTE_W-1:0]   out_byte;
   logic [CNT_W-1:0]    done_count;
   logic                last;

   modport source (output valid, kind, out_byte, done_count, last, input ready);
   modport sink   (input valid, kind, out_byte, done_count, last, output ready);
endinterface

>>> rtl/serial_line_buffer_controller.sv
// Serial line buffer controller: receive ring, line reads and counted writes.
//
// Usage:
//   req_ch carries one request per valid/ready handshake: a received byte,
//   a read request, a write request or a transmitter-ready event.
//   rsp_ch returns one or more results per request; the final one has last=1.
//   csr_we/csr_wdata write the port-open bit; writing 1 to a closed port
//   empties the ring and returns the transfer to idle.
// Sequencing:
//   Most requests give their single result in the cycle after acceptance. A
//   received byte that completes a read gives two results: the byte, then
//   the read-done result. A read request drains the ring through one RAM
//   read port: each ring byte is read in S_DRAIN and issued from S_FETCH,
//   and a closing result follows. req_ch.ready stays low until the last
//   result of the current request has been issued.
// Reset: synchronous, active high; the port is closed, the ring empty and
//   the transfer idle. Ring contents are not cleared.
// Stalls: results sit in one output register; while a result waits with
//   rsp_ch.ready low, no further result is issued and no new request is taken.
module serial_line_buffer_controller import slbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   slbc_req_if.sink         req_ch,
   slbc_rsp_if.source       rsp_ch
);

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic               open_ff, open_in;
   logic [RING_AW-1:0] head_ff, head_in;
   logic [RING_AW-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]   wanted_ff, wanted_in;
   logic [CNT_W-1:0]   moved_ff, moved_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               slot_free;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [BYTE_W-1:0]  ram_rd_data;

   // Ring storage
   slbc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (req_ch.data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (tail_ff),
      .rd_data (ram_rd_data)
   );

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && slot_free;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.out_byte   = rsp_byte_ff;
   assign rsp_ch.done_count = rsp_count_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_IDLE;
         open_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         wanted_ff    <= '0;
         moved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         open_ff      <= open_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         wanted_ff    <= wanted_in;
         moved_ff     <= moved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Sequencer: decode requests, drain ring, issue results
   always_comb begin
      logic [CNT_W-1:0] moved_inc;
      logic [CNT_W-1:0] req_cnt;

      moved_inc = moved_ff + CNT_W'(1);
      req_cnt   = clamp_count(req_ch.request_count);

      state_in     = state_ff;
      mode_in      = mode_ff;
      open_in      = open_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      wanted_in    = wanted_ff;
      moved_in     = moved_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               // every request gives at least one result here or later
               rsp_byte_in  = '0;
               rsp_count_in = '0;
               rsp_last_in  = 1'b1;
               unique case (opcode_type'(req_ch.opcode))
                  OP_RX_BYTE: begin
                     rsp_valid_in = 1'b1;
                     if (!open_ff) begin
                        rsp_kind_in = K_IGNORED;
                     end else if (mode_ff == MODE_READ) begin
                        if (req_ch.data_byte == CR_BYTE) begin
                           mode_in      = MODE_IDLE;
                           rsp_kind_in  = K_RDONE;
                           rsp_count_in = moved_ff;
                        end else begin
                           moved_in     = moved_inc;
                           rsp_kind_in  = K_BYTE;
                           rsp_byte_in  = req_ch.data_byte;
                           rsp_count_in = moved_inc;
                           if (moved_inc >= wanted_ff) begin
                              rsp_last_in = 1'b0;
                              state_in    = S_RDONE;
                           end
                        end
                     end else if (fill_ff >= FILL_W'(RING_DEPTH)) begin
                        rsp_kind_in = K_DROP;
                     end else begin
                        // push into ring
                        ram_wr_en   = 1'b1;
                        head_in     = (head_ff == RING_AW'(RING_DEPTH - 1)) ?
                                      '0 : head_ff + RING_AW'(1);
                        fill_in     = fill_ff + FILL_W'(1);
                        rsp_kind_in = K_BUF;
                     end
                  end
                  OP_READ, OP_WRITE: begin
                     if (!open_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = K_CLOSED;
                     end else if (mode_ff != MODE_IDLE) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = K_BUSY;
                     end else if (opcode_type'(req_ch.opcode) == OP_READ) begin
                        wanted_in = req_cnt;
                        moved_in  = '0;
                        state_in  = S_DRAIN;
                     end else begin
                        wanted_in    = req_cnt;
                        rsp_valid_in = 1'b1;
                        if (req_cnt == '0) begin
                           moved_in    = '0;
                           rsp_kind_in = K_WDONE;
                        end else begin
                           moved_in     = CNT_W'(1);
                           mode_in      = MODE_WRITE;
                           rsp_kind_in  = K_TX;
                           rsp_byte_in  = req_ch.data_byte;
                           rsp_count_in = CNT_W'(1);
                        end
                     end
                  end
                  OP_TX_READY: begin
                     rsp_valid_in = 1'b1;
                     if (!open_ff || mode_ff != MODE_WRITE) begin
                        rsp_kind_in = K_IGNORED;
                     end else if (moved_ff < wanted_ff) begin
                        moved_in     = moved_inc;
                        rsp_kind_in  = K_TX;
                        rsp_byte_in  = req_ch.data_byte;
                        rsp_count_in = moved_inc;
                     end else begin
                        mode_in      = MODE_IDLE;
                        rsp_kind_in  = K_WDONE;
                        rsp_count_in = moved_ff;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = K_IGNORED;
                  end
               endcase
            end
         end

         S_DRAIN: begin
            if (fill_ff != '0 && moved_ff < wanted_ff) begin
               // fetch next ring byte
               ram_rd_en = 1'b1;
               state_in  = S_FETCH;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_count_in = moved_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (moved_ff >= wanted_ff) begin
                  mode_in     = MODE_IDLE;
                  rsp_kind_in = K_RDONE;
               end else begin
                  mode_in     = MODE_READ;
                  rsp_kind_in = K_RPEND;
               end
            end
         end

         S_FETCH: begin
            if (slot_free) begin
               // pop the fetched byte
               tail_in      = (tail_ff == RING_AW'(RING_DEPTH - 1)) ?
                              '0 : tail_ff + RING_AW'(1);
               fill_in      = fill_ff - FILL_W'(1);
               rsp_valid_in = 1'b1;
               if (ram_rd_data == CR_BYTE) begin
                  mode_in      = MODE_IDLE;
                  rsp_kind_in  = K_RDONE;
                  rsp_byte_in  = '0;
                  rsp_count_in = moved_ff;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  moved_in     = moved_inc;
                  rsp_kind_in  = K_BYTE;
                  rsp_byte_in  = ram_rd_data;
                  rsp_count_in = moved_inc;
                  rsp_last_in  = 1'b0;
                  state_in     = S_DRAIN;
               end
            end
         end

         S_RDONE: begin
            if (slot_free) begin
               mode_in      = MODE_IDLE;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = K_RDONE;
               rsp_byte_in  = '0;
               rsp_count_in = moved_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Port-open register; opening a closed port empties the ring and drops any transfer
      if (csr_we) begin
         open_in = csr_wdata;
         if (csr_wdata && !open_ff) begin
            head_in   = '0;
            tail_in   = '0;
            fill_in   = '0;
            mode_in   = MODE_IDLE;
            wanted_in = '0;
            moved_in  = '0;
         end
      end
   end

   // Ring fill never exceeds its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RING_DEPTH))
      else $error("ring fill above depth");

   // A pending read only exists with an empty ring
   a_read_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && mode_ff == MODE_READ) |-> (fill_ff == '0))
      else $error("read pending with bytes left in ring");

   // Active transfers never move more than requested
   a_moved_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (moved_ff <= wanted_ff))
      else $error("transfer count beyond request");

   // An accepted request produces a result or starts the sequencer
   a_req_progress: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (rsp_valid_ff || state_ff != S_IDLE))
      else $error("request accepted without progress");

   // Ring reads happen only while draining for a read request
   a_rd_drain: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (fill_ff != '0 && moved_ff < wanted_ff))
      else $error("ring read outside a drain");

endmodule

>>> rtl/slbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> test/tb_top.sv
// Self-checking testbench for serial_line_buffer_controller: predictor, driver and monitor.
`timescale 1ns / 1ps

module tb_top;
   import slbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 20;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      opcode_type         op;
      logic [BYTE_W-1:0]  data;
      logic [CNT_W-1:0]   count;
   } req_item_type;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  data;
      logic [CNT_W-1:0]   count;
      logic               last;
   } line_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic csr_wdata;

   slbc_req_if req_ch ();
   slbc_rsp_if rsp_ch ();

   serial_line_buffer_controller dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #5 clock = ~clock;

   // Requests waiting to be driven and results the port still owes
   req_item_type    req_backlog[$];
   line_result_type awaited_results[$];
   req_item_type    cur_req;

   // Predicted port state
   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
   logic [RING_AW-1:0] ring_wr;
   logic [RING_AW-1:0] ring_rd;
   logic [FILL_W-1:0]  ring_count;
   mode_type           xfer_mode;
   logic [CNT_W-1:0]   want_cnt;
   logic [CNT_W-1:0]   moved_cnt;
   logic               port_is_open;

   bit steady_phase;
   int req_total;
   int req_sent;
   int results_seen;
   int mismatches;
   int settings_applied;
   int kind_seen [10];
   int idle_cycles;

   // Drop ring contents and return the transfer to idle
   function automatic void clear_port_state();
      ring_wr    = '0;
      ring_rd    = '0;
      ring_count = '0;
      xfer_mode  = MODE_IDLE;
      want_cnt   = '0;
      moved_cnt  = '0;
   endfunction

   function automatic void owe_result(kind_type k, logic [BYTE_W-1:0] d, logic [CNT_W-1:0] c);
      awaited_results.push_back('{k, d, c, 1'b0});
   endfunction

   // Advance the predicted port by one accepted request
   task automatic port_step(input req_item_type rq);
      line_result_type   r;
      logic [BYTE_W-1:0] b;
      bit                cr_seen;
      cr_seen = 1'b0;
      case (rq.op)
         OP_RX_BYTE: begin
            if (!port_is_open) begin
               owe_result(K_IGNORED, '0, '0);
            end else if (xfer_mode == MODE_READ) begin
               if (rq.data == CR_BYTE) begin
                  xfer_mode = MODE_IDLE;
                  owe_result(K_RDONE, '0, moved_cnt);
               end else begin
                  moved_cnt = moved_cnt + 1'b1;
                  owe_result(K_BYTE, rq.data, moved_cnt);
                  if (moved_cnt >= want_cnt) begin
                     xfer_mode = MODE_IDLE;
                     owe_result(K_RDONE, '0, moved_cnt);
                  end
               end
            end else if (ring_count >= RING_DEPTH) begin
               owe_result(K_DROP, '0, '0);
            end else begin
               ring_mem[ring_wr] = rq.data;
               ring_wr           = ring_wr + 1'b1;
               ring_count        = ring_count + 1'b1;
               owe_result(K_BUF, '0, '0);
            end
         end
         OP_READ, OP_WRITE: begin
            if (!port_is_open) begin
               owe_result(K_CLOSED, '0, '0);
            end else if (xfer_mode != MODE_IDLE) begin
               owe_result(K_BUSY, '0, '0);
            end else if (rq.op == OP_READ) begin
               want_cnt  = (rq.count > MAX_REQUEST) ? MAX_REQUEST : rq.count;
               moved_cnt = '0;
               // Drain the ring until the count is met or a carriage return shows up
               while (ring_count > 0 && moved_cnt < want_cnt && !cr_seen) begin
                  b          = ring_mem[ring_rd];
                  ring_rd    = ring_rd + 1'b1;
                  ring_count = ring_count - 1'b1;
                  if (b == CR_BYTE) begin
                     cr_seen = 1'b1;
                  end else begin
                     moved_cnt = moved_cnt + 1'b1;
                     owe_result(K_BYTE, b, moved_cnt);
                  end
               end
               if (cr_seen || moved_cnt >= want_cnt) begin
                  xfer_mode = MODE_IDLE;
                  owe_result(K_RDONE, '0, moved_cnt);
               end else begin
                  xfer_mode = MODE_READ;
                  owe_result(K_RPEND, '0, moved_cnt);
               end
            end else begin
               want_cnt  = (rq.count > MAX_REQUEST) ? MAX_REQUEST : rq.count;
               moved_cnt = '0;
               if (want_cnt == 0) begin
                  owe_result(K_WDONE, '0, '0);
               end else begin
                  moved_cnt = CNT_W'(1);
                  xfer_mode = MODE_WRITE;
                  owe_result(K_TX, rq.data, moved_cnt);
               end
            end
         end
         default: begin
            if (!port_is_open || xfer_mode != MODE_WRITE) begin
               owe_result(K_IGNORED, '0, '0);
            end else if (moved_cnt < want_cnt) begin
               moved_cnt = moved_cnt + 1'b1;
               owe_result(K_TX, rq.data, moved_cnt);
            end else begin
               xfer_mode = MODE_IDLE;
               owe_result(K_WDONE, '0, moved_cnt);
            end
         end
      endcase
      // Flag the final result of this request
      r      = awaited_results.pop_back();
      r.last = 1'b1;
      awaited_results.push_back(r);
   endtask

   function automatic bit take_gap();
      return !steady_phase && ($urandom_range(99) < 16);
   endfunction

   // Drive requests from the backlog; hold the payload while ready is low
   always @(posedge clock) begin : drive_req
      req_item_type nxt;
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.opcode        <= OP_RX_BYTE;
         req_ch.data_byte     <= '0;
         req_ch.request_count <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            port_step(cur_req);
            req_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_backlog.size() > 0 && !take_gap()) begin
               nxt                  = req_backlog.pop_front();
               cur_req              = nxt;
               req_ch.valid         <= 1'b1;
               req_ch.opcode        <= nxt.op;
               req_ch.data_byte     <= nxt.data;
               req_ch.request_count <= nxt.count;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result channel at random outside the steady phase
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && !take_gap();
   end

   function automatic void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch %0d: %s", mismatches, msg);
   endfunction

   // Compare each accepted result with the oldest owed one
   always @(posedge clock) begin : check_rsp
      line_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.kind < 10) kind_seen[rsp_ch.kind]++;
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h count %0d last %0b",
               rsp_ch.kind, rsp_ch.out_byte, rsp_ch.done_count, rsp_ch.last));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_ch.kind !== want.kind || rsp_ch.out_byte !== want.data ||
                rsp_ch.done_count !== want.count || rsp_ch.last !== want.last) begin
               report_mismatch($sformatf(
                  "expected kind %0d byte %02h count %0d last %0b, got %0d %02h %0d %0b",
                  want.kind, want.data, want.count, want.last,
                  rsp_ch.kind, rsp_ch.out_byte, rsp_ch.done_count, rsp_ch.last));
            end
         end
      end
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
            idle_cycles, awaited_results.size());
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_req(opcode_type op, logic [BYTE_W-1:0] data, logic [CNT_W-1:0] count);
      req_backlog.push_back('{op, data, count});
      req_total++;
   endtask

   // Wait until every request is taken and every result is back
   task automatic wait_quiet();
      @(negedge clock);
      while (req_backlog.size() > 0 || req_ch.valid || awaited_results.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_port_open(logic value);
      wait_quiet();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (value && !port_is_open) clear_port_state();
      port_is_open = value;
      settings_applied++;
   endtask

   function automatic logic [BYTE_W-1:0] line_byte(int cr_pct);
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(255));
      if ($urandom_range(99) < cr_pct) b = CR_BYTE;
      else if (b == CR_BYTE) b = 8'h20;
      return b;
   endfunction

   function automatic logic [CNT_W-1:0] short_count();
      int pick;
      pick = $urandom_range(99);
      if (pick < 6) return '0;
      if (pick < 10) return MAX_REQUEST;
      return CNT_W'($urandom_range(1, 10));
   endfunction

   function automatic logic [BYTE_W-1:0] any_byte();
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [CNT_W-1:0] any_count();
      return CNT_W'($urandom_range(63));
   endfunction

   // Queue random request sequences, mostly complete reads and writes
   task automatic random_traffic(int n_items);
      int start;
      int pick;
      int k;
      int i;
      logic [CNT_W-1:0] cnt;
      start = req_total;
      while (req_total - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            // Line read: prefill a little, request, then feed the rest
            k = $urandom_range(6);
            repeat (k) queue_req(OP_RX_BYTE, line_byte(8), any_count());
            cnt = short_count();
            queue_req(OP_READ, any_byte(), cnt);
            k = $urandom_range(cnt + 2);
            repeat (k) queue_req(OP_RX_BYTE, line_byte(10), any_count());
         end else if (pick < 65) begin
            // Counted write followed by its ready events
            cnt = short_count();
            queue_req(OP_WRITE, any_byte(), cnt);
            for (i = 0; i <= cnt; i++) begin
               if ($urandom_range(9) == 0) queue_req(OP_RX_BYTE, line_byte(10), any_count());
               queue_req(OP_TX_READY, any_byte(), any_count());
            end
         end else if (pick < 75) begin
            k = $urandom_range(3, 12);
            repeat (k) queue_req(OP_RX_BYTE, line_byte(5), any_count());
         end else if (pick < 85) begin
            k = $urandom_range(1, 3);
            repeat (k) queue_req(opcode_type'($urandom_range(3)), any_byte(), any_count());
         end else if (pick < 92) begin
            // Broken sequence: request left short of completion
            cnt = short_count();
            if ($urandom_range(1)) begin
               queue_req(OP_WRITE, any_byte(), cnt);
               k = (cnt > 1) ? $urandom_range(cnt - 1) : 0;
               repeat (k) queue_req(OP_TX_READY, any_byte(), any_count());
            end else begin
               queue_req(OP_READ, any_byte(), cnt);
            end
         end else begin
            // Collide requests to provoke busy rejections
            queue_req(OP_READ, any_byte(), short_count());
            queue_req(OP_WRITE, any_byte(), short_count());
            queue_req(OP_TX_READY, any_byte(), any_count());
            queue_req(OP_RX_BYTE, CR_BYTE, any_count());
         end
         // Hold the sender now and then until the port is quiet
         if ($urandom_range(11) == 0) wait_quiet();
      end
   endtask

   initial begin
      csr_we               = 1'b0;
      csr_wdata            = 1'b0;
      foreach (ring_mem[i]) ring_mem[i] = '0;
      clear_port_state();
      port_is_open = 1'b0;
      steady_phase = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Closed port: requests rejected, events ignored
      queue_req(OP_READ, 8'h00, 6'd5);
      queue_req(OP_WRITE, 8'hFF, 6'd5);
      queue_req(OP_RX_BYTE, 8'h41, 6'd0);
      queue_req(OP_TX_READY, 8'h42, 6'd0);
      write_port_open(1'b1);

      // Open port: extremes, carriage return in ring, zero counts, busy, writes
      queue_req(OP_RX_BYTE, 8'h00, 6'd0);
      queue_req(OP_RX_BYTE, 8'hFF, 6'd63);
      queue_req(OP_RX_BYTE, CR_BYTE, 6'd0);
      queue_req(OP_RX_BYTE, 8'h41, 6'd0);
      queue_req(OP_READ, 8'h00, MAX_REQUEST);
      queue_req(OP_READ, 8'h00, 6'd0);
      queue_req(OP_READ, 8'hFF, 6'd2);
      queue_req(OP_READ, 8'h00, 6'd1);
      queue_req(OP_WRITE, 8'h00, 6'd1);
      queue_req(OP_TX_READY, 8'h33, 6'd0);
      queue_req(OP_RX_BYTE, 8'h55, 6'd0);
      queue_req(OP_WRITE, 8'h00, 6'd0);
      queue_req(OP_WRITE, 8'hAA, 6'd2);
      queue_req(OP_RX_BYTE, 8'h12, 6'd0);
      queue_req(OP_TX_READY, 8'h01, 6'd63);
      queue_req(OP_TX_READY, 8'h02, 6'd0);
      queue_req(OP_READ, 8'h00, 6'd1);
      queue_req(OP_READ, 8'h00, 6'd3);
      queue_req(OP_RX_BYTE, 8'h07, 6'd0);
      queue_req(OP_RX_BYTE, CR_BYTE, 6'd0);
      wait_quiet();

      // Overfill the ring, drain it, then finish a read on live bytes
      steady_phase = 1'b1;
      repeat (66) queue_req(OP_RX_BYTE, line_byte(0), any_count());
      queue_req(OP_READ, any_byte(), MAX_REQUEST);
      queue_req(OP_READ, any_byte(), 6'd5);
      queue_req(OP_RX_BYTE, line_byte(0), any_count());
      queue_req(OP_RX_BYTE, CR_BYTE, any_count());
      random_traffic(170);
      wait_quiet();
      steady_phase = 1'b0;

      // Leave a read pending across a redundant open, then close and reopen
      queue_req(OP_RX_BYTE, line_byte(0), any_count());
      queue_req(OP_READ, any_byte(), 6'd40);
      write_port_open(1'b1);
      queue_req(OP_RX_BYTE, line_byte(0), any_count());
      write_port_open(1'b0);
      repeat (20) queue_req(opcode_type'($urandom_range(3)), any_byte(), any_count());
      write_port_open(1'b0);
      write_port_open(1'b1);
      queue_req(OP_READ, any_byte(), 6'd5);
      queue_req(OP_RX_BYTE, CR_BYTE, any_count());
      random_traffic(230);

      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) mismatches++;
      $display("Run covered %0d requests and %0d results over %0d port settings",
         req_sent, results_seen, settings_applied);
      $display("  reads done %0d, ring drops %0d, writes done %0d, busy %0d, closed %0d",
         kind_seen[K_RDONE], kind_seen[K_DROP], kind_seen[K_WDONE], kind_seen[K_BUSY],
         kind_seen[K_CLOSED]);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
